/* rtl/cto_pkg.sv */
// Package with the shared types, constants and codes of the command timeout tracker.
package cto_pkg;

    localparam int CHANNELS    = 16;
    localparam int PEERS       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int QDEPTH      = 2;

    localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PR_IW  = (PEERS > 1) ? $clog2(PEERS) : 1;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int QP_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W   = $clog2(QDEPTH + 1);
    localparam int ADDR_W = 5;

    localparam logic [15:0] RST_BASE    = 16'd3000;
    localparam logic [15:0] RST_STEP    = 16'd200;
    localparam logic [15:0] RST_MIN     = 16'd3000;
    localparam logic [15:0] RST_MAX     = 16'd15000;
    localparam logic [31:0] RST_OFFLINE = 32'd30000;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_BASE    = 3'd0;
    localparam logic [2:0] REG_STEP    = 3'd1;
    localparam logic [2:0] REG_MIN     = 3'd2;
    localparam logic [2:0] REG_MAX     = 3'd3;
    localparam logic [2:0] REG_OFFLINE = 3'd4;

    // Request types on the input channel.
    localparam logic [1:0] REQ_ISSUE = 2'd0;
    localparam logic [1:0] REQ_RESP  = 2'd1;
    localparam logic [1:0] REQ_SCAN  = 2'd2;

    // Response kinds.
    localparam logic [1:0] KIND_PLAIN     = 2'd0;
    localparam logic [1:0] KIND_HEARTBEAT = 2'd1;

    typedef enum logic [3:0] {
        EV_ACCEPTED    = 4'd0,
        EV_INVALID     = 4'd1,
        EV_BUSY        = 4'd2,
        EV_SEND_FAILED = 4'd3,
        EV_DONE_OK     = 4'd4,
        EV_DONE_FAILED = 4'd5,
        EV_TIMEOUT     = 4'd6,
        EV_HEARTBEAT   = 4'd7,
        EV_PEER_ONLINE = 4'd8
    } t_event;

    typedef enum logic [1:0] {
        OP_ISSUE = 2'd0,
        OP_RESP  = 2'd1,
        OP_SCAN  = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  channel;
        logic [31:0] timeout;
        logic        radio_accepted;
        logic [1:0]  resp_kind;
        logic        status_good;
        logic        online_text;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  event_channel;
        logic [31:0] timeout_used;
        logic [31:0] success_count;
        logic        last;
    } t_result;

    typedef struct packed {
        logic  push;
        logic  pop;
    } t_qctl;

endpackage

/* rtl/cto_front.sv */
// Front end: configuration registers, input acceptance and item classification.
module cto_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [cto_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_req_type,
    input  logic [7:0]                i_channel,
    input  logic [7:0]                i_feed_length,
    input  logic [31:0]               i_timeout_request,
    input  logic                      i_radio_accepted,
    input  logic [1:0]                i_resp_kind,
    input  logic                      i_status_good,
    input  logic                      i_online_text,
    input  logic [31:0]               i_now_ms,
    input  logic                      i_q_full,
    output logic                      o_push,
    output cto_pkg::t_item            o_item,
    output logic [31:0]               o_offline_after
);
    import cto_pkg::*;

    logic [15:0] r_base, r_step, r_min, r_max;
    logic [31:0] r_offline;
    logic [2:0]  reg_idx;
    logic        wr_en;
    logic [23:0] prod_sum;
    logic [23:0] lo_clamped;
    logic [23:0] clamped;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= RST_BASE;
            r_step    <= RST_STEP;
            r_min     <= RST_MIN;
            r_max     <= RST_MAX;
            r_offline <= RST_OFFLINE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BASE:    r_base    <= pwdata[15:0];
                REG_STEP:    r_step    <= pwdata[15:0];
                REG_MIN:     r_min     <= pwdata[15:0];
                REG_MAX:     r_max     <= pwdata[15:0];
                REG_OFFLINE: r_offline <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BASE:    prdata = {16'd0, r_base};
            REG_STEP:    prdata = {16'd0, r_step};
            REG_MIN:     prdata = {16'd0, r_min};
            REG_MAX:     prdata = {16'd0, r_max};
            REG_OFFLINE: prdata = r_offline;
            default:     prdata = 32'd0;
        endcase
    end

    // The computed timeout never exceeds 24 bits: 65535 + 255 * 65535 < 2^24.
    assign prod_sum   = 24'(r_base) + 24'(i_feed_length) * 24'(r_step);
    assign lo_clamped = (prod_sum < 24'(r_min)) ? 24'(r_min) : prod_sum;
    assign clamped    = (lo_clamped > 24'(r_max)) ? 24'(r_max) : lo_clamped;

    always_comb begin
        o_item.op             = t_op'(i_req_type);
        o_item.channel        = i_channel;
        o_item.timeout        = (i_timeout_request != 32'd0) ? i_timeout_request
                                                             : {8'd0, clamped};
        o_item.radio_accepted = i_radio_accepted;
        o_item.resp_kind      = i_resp_kind;
        o_item.status_good    = i_status_good;
        o_item.online_text    = i_online_text;
        o_item.now_ms         = i_now_ms;
    end

    // Unused request codes are taken and dropped without reaching the queue.
    assign o_in_ready      = !i_q_full;
    assign o_push          = i_in_valid && !i_q_full &&
                             (i_req_type == REQ_ISSUE || i_req_type == REQ_RESP ||
                              i_req_type == REQ_SCAN);
    assign o_offline_after = r_offline;

endmodule

/* rtl/cto_queue.sv */
// Short queue of classified items between the front and back ends.
module cto_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cto_pkg::t_qctl i_ctl,
    input  cto_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output cto_pkg::t_item o_item
);
    import cto_pkg::*;

    t_item            r_mem [QDEPTH];
    logic [QP_W-1:0]  r_wr, r_rd;
    logic [QC_W-1:0]  r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == QC_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_ctl.push && !o_full;
    assign do_pop  = i_ctl.pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QP_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QP_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + QC_W'(do_push) - QC_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

/* rtl/cto_back.sv */
// Back end: channel and peer state, completion logic, timeout scan and result register.
module cto_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  cto_pkg::t_item   i_item,
    output logic             o_pop,
    input  logic [31:0]      i_offline_after,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output cto_pkg::t_result o_result
);
    import cto_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_ISSUE    = 6'b000010,
        ST_PEER     = 6'b000100,
        ST_MAIN     = 6'b001000,
        ST_SCAN_CHK = 6'b010000,
        ST_SCAN_EMT = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [CH_IW-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CHANNELS-1:0] r_mask, n_mask;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic [CHANNELS-1:0] r_busy;
    logic [31:0]         r_issue_time [CHANNELS];
    logic [31:0]         r_armed      [CHANNELS];
    logic [31:0]         r_succ       [CHANNELS];
    logic [31:0]         r_session;
    logic [PEERS-1:0]    r_seen;
    logic [31:0]         r_peer_time  [PEERS];

    logic [CH_IW-1:0]    ch_idx;
    logic [PR_IW-1:0]    pr_idx;
    logic                ch_ok, pr_ok, out_free, stale, second, expired;
    logic [31:0]         succ_cur;
    logic [CHANNELS-1:0] mask_hi;
    logic                busy_set, busy_clr, armed_we, issue_we, succ_we, peer_we;
    logic                session_inc;
    logic [CH_IW-1:0]    clr_idx;

    assign ch_idx   = i_item.channel[CH_IW-1:0];
    assign pr_idx   = i_item.channel[PR_IW-1:0];
    assign ch_ok    = (i_item.channel < 8'(CHANNELS));
    assign pr_ok    = (i_item.channel < 8'(PEERS));
    assign out_free = !r_out_valid || i_out_ready;
    assign succ_cur = r_succ[ch_idx];
    assign stale    = pr_ok && (!r_seen[pr_idx] ||
                      (i_item.now_ms - r_peer_time[pr_idx]) >= i_offline_after);
    assign second   = (i_item.resp_kind == KIND_HEARTBEAT) ||
                      (i_item.resp_kind == KIND_PLAIN &&
                       (i_item.online_text || (ch_ok && r_busy[ch_idx])));
    assign expired  = r_busy[r_idx] &&
                      ((i_item.now_ms - r_issue_time[r_idx]) > r_armed[r_idx]);
    assign mask_hi  = (r_mask >> r_idx) >> 1;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_mask      = r_mask;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        busy_set    = 1'b0;
        busy_clr    = 1'b0;
        clr_idx     = ch_idx;
        armed_we    = 1'b0;
        issue_we    = 1'b0;
        succ_we     = 1'b0;
        peer_we     = 1'b0;
        session_inc = 1'b0;

        n_out.event_channel = i_item.channel;
        n_out.timeout_used  = 32'd0;
        n_out.success_count = 32'd0;
        n_out.last          = 1'b1;

        case (r_state)
            ST_IDLE: begin
                n_out = r_out;
                if (i_q_valid) begin
                    case (i_item.op)
                        OP_ISSUE: n_state = ST_ISSUE;
                        OP_RESP:  n_state = ST_PEER;
                        OP_SCAN: begin
                            n_state = ST_SCAN_CHK;
                            n_idx   = '0;
                            n_cnt   = '0;
                        end
                        default:  o_pop = 1'b1;
                    endcase
                end
            end
            ST_ISSUE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (!ch_ok) begin
                        n_out.event_res = EV_INVALID;
                    end else if (r_busy[ch_idx]) begin
                        n_out.event_res = EV_BUSY;
                    end else begin
                        armed_we = 1'b1;
                        if (i_item.radio_accepted) begin
                            busy_set           = 1'b1;
                            issue_we           = 1'b1;
                            n_out.event_res    = EV_ACCEPTED;
                            n_out.timeout_used = i_item.timeout;
                        end else begin
                            n_out.event_res = EV_SEND_FAILED;
                        end
                    end
                    o_pop   = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_out = r_out;
                end
            end
            ST_PEER: begin
                n_out.event_res = EV_PEER_ONLINE;
                n_out.last      = !second;
                if (!stale || out_free) begin
                    n_out_valid = stale || n_out_valid;
                    if (!stale) begin
                        n_out = r_out;
                    end
                    peer_we = pr_ok;
                    if (second) begin
                        n_state = ST_MAIN;
                    end else begin
                        o_pop   = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_out = r_out;
                end
            end
            ST_MAIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (i_item.resp_kind == KIND_HEARTBEAT || i_item.online_text) begin
                        n_out.event_res = EV_HEARTBEAT;
                    end else begin
                        busy_clr = 1'b1;
                        if (i_item.status_good) begin
                            succ_we             = 1'b1;
                            session_inc         = 1'b1;
                            n_out.event_res     = EV_DONE_OK;
                            n_out.success_count = succ_cur + 32'd1;
                        end else begin
                            n_out.event_res     = EV_DONE_FAILED;
                            n_out.success_count = succ_cur;
                        end
                    end
                    o_pop   = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_out = r_out;
                end
            end
            ST_SCAN_CHK: begin
                n_out         = r_out;
                n_mask[r_idx] = expired;
                if (r_idx == CH_IW'(CHANNELS - 1)) begin
                    n_idx   = '0;
                    n_state = ST_SCAN_EMT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_SCAN_EMT: begin
                n_out.event_res     = EV_TIMEOUT;
                n_out.event_channel = 8'(r_idx);
                n_out.last          = (r_cnt == CNT_W'(MAX_RESULTS - 1)) ||
                                      (mask_hi == '0);
                if (r_mask[r_idx]) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        busy_clr    = 1'b1;
                        clr_idx     = r_idx;
                        n_cnt       = r_cnt + 1'b1;
                        if (n_out.last) begin
                            o_pop   = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end else begin
                        n_out = r_out;
                    end
                end else begin
                    n_out = r_out;
                    if (r_idx == CH_IW'(CHANNELS - 1)) begin
                        o_pop   = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_out   = r_out;
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_busy      <= '0;
            r_seen      <= '0;
            r_session   <= 32'd0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_succ[k] <= 32'd0;
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (busy_set) begin
                r_busy[ch_idx] <= 1'b1;
            end
            if (busy_clr) begin
                r_busy[clr_idx] <= 1'b0;
            end
            if (peer_we) begin
                r_seen[pr_idx] <= 1'b1;
            end
            if (succ_we) begin
                r_succ[ch_idx] <= succ_cur + 32'd1;
            end
            if (session_inc) begin
                r_session <= r_session + 32'd1;
            end
        end
    end

    // Timing stores are only read for busy channels or seen peers, so they need no reset.
    always_ff @(posedge i_clk) begin
        r_mask <= n_mask;
        r_out  <= n_out;
        if (armed_we) begin
            r_armed[ch_idx] <= i_item.timeout;
        end
        if (issue_we) begin
            r_issue_time[ch_idx] <= i_item.now_ms;
        end
        if (peer_we) begin
            r_peer_time[pr_idx] <= i_item.now_ms;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

/* rtl/per_channel_command_timeout_tracker.sv */
// Top level of the per-channel command timeout tracker.
//
//  Channel | Handshake                    | Carries
//  --------+------------------------------+-----------------------------------------
//  input   | i_in_valid / o_in_ready      | request: issue, response or scan
//  output  | o_out_valid / i_out_ready    | event with channel, timeout, count, last
//  config  | psel, penable, pwrite, pready| five timeout and offline registers
//
// An issue passes the queue and the issue state before its result is registered;
// a response passes the peer state and, for a second event, the main state. A
// scan sweeps the channels once to mark expired timers, then walks them with a
// result per marked channel while the output is free. The back end handles one
// item at a time; a two-entry queue lets the front keep accepting while it works.
// Reset is synchronous and active low and leaves no state to clear afterwards. A
// stalled output holds its result register and the back end waits on it.
module per_channel_command_timeout_tracker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cto_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_req_type,
    input  logic [7:0]                 i_channel,
    input  logic [7:0]                 i_feed_length,
    input  logic [31:0]                i_timeout_request,
    input  logic                       i_radio_accepted,
    input  logic [1:0]                 i_resp_kind,
    input  logic                       i_status_good,
    input  logic                       i_online_text,
    input  logic [31:0]                i_now_ms,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [3:0]                 o_event_res,
    output logic [7:0]                 o_event_channel,
    output logic [31:0]                o_timeout_used,
    output logic [31:0]                o_success_count,
    output logic                       o_last
);
    import cto_pkg::*;

    t_item   front_item, head_item;
    t_qctl   qctl;
    t_result result;
    logic    q_full, q_valid, push, pop;
    logic [31:0] offline_after;

    // The configuration port never inserts wait states.
    assign pready = 1'b1;

    cto_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_channel        (i_channel),
        .i_feed_length    (i_feed_length),
        .i_timeout_request(i_timeout_request),
        .i_radio_accepted (i_radio_accepted),
        .i_resp_kind      (i_resp_kind),
        .i_status_good    (i_status_good),
        .i_online_text    (i_online_text),
        .i_now_ms         (i_now_ms),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_item           (front_item),
        .o_offline_after  (offline_after)
    );

    assign qctl.push = push;
    assign qctl.pop  = pop;

    cto_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (qctl),
        .i_item (front_item),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_item (head_item)
    );

    cto_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_item         (head_item),
        .o_pop          (pop),
        .i_offline_after(offline_after),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result       (result)
    );

    assign o_event_res     = result.event_res;
    assign o_event_channel = result.event_channel;
    assign o_timeout_used  = result.timeout_used;
    assign o_success_count = result.success_count;
    assign o_last          = result.last;

endmodule

/* rtl/cto_checker.sv */
// Port-level checker for the command timeout tracker and its bind.
module cto_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       pready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [3:0]                 o_event_res,
    input logic [31:0]                o_timeout_used,
    input logic [31:0]                o_success_count
);
    import cto_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_res))
        else $error("output transaction changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_event_res <= EV_PEER_ONLINE)
        else $error("event code out of range");

    a_tmo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_res != EV_ACCEPTED |-> o_timeout_used == 32'd0)
        else $error("timeout shown on a non-accept event");

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_res != EV_DONE_OK && o_event_res != EV_DONE_FAILED
        |-> o_success_count == 32'd0)
        else $error("count shown on a non-completion event");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

endmodule

bind per_channel_command_timeout_tracker cto_checker u_cto_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .pready         (pready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_event_res    (o_event_res),
    .o_timeout_used (o_timeout_used),
    .o_success_count(o_success_count)
);

/* tb/sv/cto_event_checker.sv */
// Checker for the command timeout tracker: predicts events from accepted requests and compares them.
`timescale 1ns / 1ps

module cto_event_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cto_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [1:0]                  i_req_type,
    input  logic [7:0]                  i_channel,
    input  logic [7:0]                  i_feed_length,
    input  logic [31:0]                 i_timeout_request,
    input  logic                        i_radio_accepted,
    input  logic [1:0]                  i_resp_kind,
    input  logic                        i_status_good,
    input  logic                        i_online_text,
    input  logic [31:0]                 i_now_ms,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [3:0]                  i_event_res,
    input  logic [7:0]                  i_event_channel,
    input  logic [31:0]                 i_timeout_used,
    input  logic [31:0]                 i_success_count,
    input  logic                        i_last,
    output int                          o_mismatches,
    output int                          o_outstanding,
    output int                          o_events_seen
);
    import cto_pkg::*;

    logic [15:0] base_ms, step_ms, min_ms, max_ms;
    logic [31:0] offline_ms;
    logic        busy     [CHANNELS];
    logic [31:0] issued_at[CHANNELS];
    logic [31:0] armed_ms [CHANNELS];
    logic [31:0] ok_count [CHANNELS];
    logic [31:0] session_ok;
    logic        seen     [PEERS];
    logic [31:0] seen_at  [PEERS];

    t_result expected_events[$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        o_events_seen = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_mismatches++;
    endtask

    task automatic add_event(input t_event ev, input logic [7:0] ch,
                             input logic [31:0] tmo, input logic [31:0] cnt);
        t_result r;
        r.event_res     = ev;
        r.event_channel = ch;
        r.timeout_used  = tmo;
        r.success_count = cnt;
        r.last          = 1'b0;
        expected_events.push_back(r);
    endtask

    task automatic predict_events(input logic [1:0] req, input logic [7:0] ch,
                                  input logic [7:0] flen, input logic [31:0] treq,
                                  input logic radio, input logic [1:0] kind,
                                  input logic good, input logic online,
                                  input logic [31:0] now);
        int          n;
        logic [31:0] t;
        logic        stale;
        n = 0;
        case (req)
            REQ_ISSUE: begin
                if (ch >= CHANNELS) begin
                    add_event(EV_INVALID, ch, 0, 0); n++;
                end else if (busy[ch]) begin
                    add_event(EV_BUSY, ch, 0, 0); n++;
                end else begin
                    if (treq == 0) begin
                        t = {16'd0, base_ms} + 32'(flen) * {16'd0, step_ms};
                        if (t < {16'd0, min_ms}) t = {16'd0, min_ms};
                        if (t > {16'd0, max_ms}) t = {16'd0, max_ms};
                    end else begin
                        t = treq;
                    end
                    // A rejected send still leaves the new timeout armed.
                    armed_ms[ch] = t;
                    if (radio) begin
                        busy[ch]      = 1'b1;
                        issued_at[ch] = now;
                        add_event(EV_ACCEPTED, ch, t, 0); n++;
                    end else begin
                        add_event(EV_SEND_FAILED, ch, 0, 0); n++;
                    end
                end
            end
            REQ_RESP: begin
                if (ch < PEERS) begin
                    stale = !seen[ch] || (now - seen_at[ch]) >= offline_ms;
                    seen[ch]    = 1'b1;
                    seen_at[ch] = now;
                    if (stale) begin
                        add_event(EV_PEER_ONLINE, ch, 0, 0); n++;
                    end
                end
                if (kind == KIND_PLAIN) begin
                    if (online) begin
                        add_event(EV_HEARTBEAT, ch, 0, 0); n++;
                    end else if (ch < CHANNELS && busy[ch]) begin
                        busy[ch] = 1'b0;
                        if (good) begin
                            ok_count[ch]++;
                            session_ok++;
                            add_event(EV_DONE_OK, ch, 0, ok_count[ch]); n++;
                        end else begin
                            add_event(EV_DONE_FAILED, ch, 0, ok_count[ch]); n++;
                        end
                    end
                end else if (kind == KIND_HEARTBEAT) begin
                    add_event(EV_HEARTBEAT, ch, 0, 0); n++;
                end
            end
            REQ_SCAN: begin
                for (int i = 0; i < CHANNELS && n < MAX_RESULTS; i++) begin
                    if (busy[i] && (now - issued_at[i]) > armed_ms[i]) begin
                        busy[i] = 1'b0;
                        add_event(EV_TIMEOUT, 8'(i), 0, 0); n++;
                    end
                end
            end
            default: ;
        endcase
        if (n > 0) expected_events[$].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            base_ms    = RST_BASE;
            step_ms    = RST_STEP;
            min_ms     = RST_MIN;
            max_ms     = RST_MAX;
            offline_ms = RST_OFFLINE;
            session_ok = 0;
            for (int i = 0; i < CHANNELS; i++) begin
                busy[i]      = 1'b0;
                issued_at[i] = 0;
                armed_ms[i]  = 32'd5000;
                ok_count[i]  = 0;
            end
            for (int i = 0; i < PEERS; i++) begin
                seen[i]    = 1'b0;
                seen_at[i] = 0;
            end
            expected_events.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_BASE:    base_ms    = pwdata[15:0];
                    REG_STEP:    step_ms    = pwdata[15:0];
                    REG_MIN:     min_ms     = pwdata[15:0];
                    REG_MAX:     max_ms     = pwdata[15:0];
                    REG_OFFLINE: offline_ms = pwdata;
                    default: ;
                endcase
            end
            // Results are compared before new predictions are queued; no result
            // can leave in the same cycle its request goes in.
            if (i_out_valid && i_out_ready) begin
                o_events_seen++;
                if (expected_events.size() == 0) begin
                    report_mismatch("unexpected event", i_event_res, 0);
                end else begin
                    want = expected_events.pop_front();
                    if (i_event_res != want.event_res)
                        report_mismatch("event_res", i_event_res, want.event_res);
                    if (i_event_channel != want.event_channel)
                        report_mismatch("event_channel", i_event_channel,
                                        want.event_channel);
                    if (i_timeout_used != want.timeout_used)
                        report_mismatch("timeout_used", i_timeout_used, want.timeout_used);
                    if (i_success_count != want.success_count)
                        report_mismatch("success_count", i_success_count,
                                        want.success_count);
                    if (i_last != want.last)
                        report_mismatch("last", i_last, want.last);
                end
            end
            if (i_in_valid && i_in_ready)
                predict_events(i_req_type, i_channel, i_feed_length, i_timeout_request,
                               i_radio_accepted, i_resp_kind, i_status_good,
                               i_online_text, i_now_ms);
        end
        o_outstanding = expected_events.size();
    end

endmodule

/* tb/sv/per_channel_command_timeout_tracker_tb.sv */
// Testbench top for the per-channel command timeout tracker: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module per_channel_command_timeout_tracker_tb;
    import cto_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 80;
    localparam int HOLD_OFF   = 400;

    typedef struct {
        logic [1:0]  req;
        logic [7:0]  ch;
        logic [7:0]  flen;
        logic [31:0] treq;
        logic        radio;
        logic [1:0]  kind;
        logic        good;
        logic        online;
        logic [31:0] now;
    } t_request;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_req_type = '0;
    logic [7:0]         i_channel = '0;
    logic [7:0]         i_feed_length = '0;
    logic [31:0]        i_timeout_request = '0;
    logic               i_radio_accepted = 1'b0;
    logic [1:0]         i_resp_kind = '0;
    logic               i_status_good = 1'b0;
    logic               i_online_text = 1'b0;
    logic [31:0]        i_now_ms = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [3:0]         o_event_res;
    logic [7:0]         o_event_channel;
    logic [31:0]        o_timeout_used;
    logic [31:0]        o_success_count;
    logic               o_last;

    int mismatches, outstanding, events_seen;
    int requests_sent = 0;
    int settings_used = 0;
    int idle_cycles = 0;
    bit calm_stretch = 1'b0;   // no idling on either side while set
    bit hold_receiver = 1'b0;  // asks the receiver for one long hold-off
    logic [31:0] clock_ms = 32'd1000;

    per_channel_command_timeout_tracker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_req_type(i_req_type), .i_channel(i_channel), .i_feed_length(i_feed_length),
        .i_timeout_request(i_timeout_request), .i_radio_accepted(i_radio_accepted),
        .i_resp_kind(i_resp_kind), .i_status_good(i_status_good),
        .i_online_text(i_online_text), .i_now_ms(i_now_ms),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_event_res(o_event_res), .o_event_channel(o_event_channel),
        .o_timeout_used(o_timeout_used), .o_success_count(o_success_count),
        .o_last(o_last)
    );

    cto_event_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_req_type(i_req_type), .i_channel(i_channel), .i_feed_length(i_feed_length),
        .i_timeout_request(i_timeout_request), .i_radio_accepted(i_radio_accepted),
        .i_resp_kind(i_resp_kind), .i_status_good(i_status_good),
        .i_online_text(i_online_text), .i_now_ms(i_now_ms),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_event_res(o_event_res), .i_event_channel(o_event_channel),
        .i_timeout_used(o_timeout_used), .i_success_count(o_success_count),
        .i_last(o_last),
        .o_mismatches(mismatches), .o_outstanding(outstanding),
        .o_events_seen(events_seen)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // The receiver stalls about a quarter of the time. On request it holds off
    // for a long stretch so that the internal queue fills and the input stalls.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_receiver) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
                hold_receiver = 1'b0;
            end else if (calm_stretch) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 25);
            end
        end
    end

    // The watchdog ends a run in which nothing has moved for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic t_request make_request(input logic [1:0] req, input logic [7:0] ch,
                                              input logic [7:0] flen,
                                              input logic [31:0] treq, input logic radio,
                                              input logic [1:0] kind, input logic good,
                                              input logic online, input logic [31:0] now);
        t_request r;
        r.req = req; r.ch = ch; r.flen = flen; r.treq = treq; r.radio = radio;
        r.kind = kind; r.good = good; r.online = online; r.now = now;
        return r;
    endfunction

    // Random requests are mostly well formed: issues and responses on the
    // sixteen real channels, with a steadily advancing clock so that scans find
    // expired timers. The rest is noise: out-of-range channels, huge explicit
    // timeouts, unused request types and clock jumps.
    function automatic t_request random_request();
        t_request r;
        int       pick;
        pick     = $urandom_range(99);
        r.req    = (pick < 35) ? REQ_ISSUE : (pick < 75) ? REQ_RESP :
                   (pick < 95) ? REQ_SCAN : 2'd3;
        r.ch     = ($urandom_range(99) < 90) ? 8'($urandom_range(CHANNELS - 1))
                                             : 8'($urandom_range(255));
        r.flen   = 8'($urandom_range(255));
        pick     = $urandom_range(99);
        r.treq   = (pick < 65) ? 32'd0 : (pick < 90) ? 32'($urandom_range(1, 20000))
                                                     : $urandom;
        r.radio  = ($urandom_range(99) < 85);
        pick     = $urandom_range(99);
        r.kind   = (pick < 70) ? KIND_PLAIN : (pick < 85) ? KIND_HEARTBEAT
                                            : 2'($urandom_range(2, 3));
        r.good   = ($urandom_range(99) < 70);
        r.online = ($urandom_range(99) < 15);
        clock_ms = clock_ms + 32'($urandom_range(0, 3000));
        r.now    = ($urandom_range(99) < 3) ? $urandom : clock_ms;
        return r;
    endfunction

    // Offers one request and returns at the edge that accepts it. Valid stays
    // high afterwards so the next request can follow without a gap.
    task automatic send_request(input t_request r);
        if (!calm_stretch && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_req_type        <= r.req;
        i_channel         <= r.ch;
        i_feed_length     <= r.flen;
        i_timeout_request <= r.treq;
        i_radio_accepted  <= r.radio;
        i_resp_kind       <= r.kind;
        i_status_good     <= r.good;
        i_online_text     <= r.online;
        i_now_ms          <= r.now;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        requests_sent++;
    endtask

    // Stops offering and waits until every predicted event is out, then lets
    // a scan that produced nothing finish its sweep.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] base, input logic [15:0] step,
                                 input logic [15:0] lo, input logic [15:0] hi,
                                 input logic [31:0] offline);
        reg_write(REG_BASE, {16'd0, base});
        reg_write(REG_STEP, {16'd0, step});
        reg_write(REG_MIN, {16'd0, lo});
        reg_write(REG_MAX, {16'd0, hi});
        reg_write(REG_OFFLINE, offline);
        settings_used++;
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) send_request(random_request());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        settings_used = 1;

        // Directed part under the reset settings.
        send_request(make_request(REQ_ISSUE, 8'd0, 8'd0, 32'd0, 1'b1, 0, 0, 0, 32'd100));
        send_request(make_request(REQ_ISSUE, 8'd15, 8'd255, 32'd0, 1'b1, 0, 0, 0, 32'd100));
        send_request(make_request(REQ_ISSUE, 8'd16, 8'd0, 32'd0, 1'b1, 0, 0, 0, 32'd100));
        send_request(make_request(REQ_ISSUE, 8'd255, 8'd255, 32'hFFFF_FFFF, 1'b1,
                                  2'd3, 1, 1, 32'hFFFF_FFFF));
        // Second issue on a channel that is still waiting.
        send_request(make_request(REQ_ISSUE, 8'd0, 8'd9, 32'd0, 1'b1, 0, 0, 0, 32'd110));
        // Rejected by the radio: timeout armed, channel stays free.
        send_request(make_request(REQ_ISSUE, 8'd3, 8'd4, 32'd0, 1'b0, 0, 0, 0, 32'd120));
        send_request(make_request(REQ_ISSUE, 8'd5, 8'd0, 32'hFFFF_FFFF, 1'b1,
                                  0, 0, 0, 32'd200));
        send_request(make_request(REQ_ISSUE, 8'd6, 8'd0, 32'd1, 1'b1, 0, 0, 0, 32'd200));
        send_request(make_request(REQ_RESP, 8'd0, 8'd0, 32'd0, 1'b0, KIND_PLAIN,
                                  1, 0, 32'd500));
        send_request(make_request(REQ_RESP, 8'd15, 8'd0, 32'd0, 1'b0, KIND_PLAIN,
                                  0, 0, 32'd600));
        send_request(make_request(REQ_RESP, 8'd0, 8'd0, 32'd0, 1'b0, KIND_PLAIN,
                                  1, 1, 32'd700));
        // Peer out of range: only the heartbeat event.
        send_request(make_request(REQ_RESP, 8'd200, 8'd0, 32'd0, 1'b0, KIND_HEARTBEAT,
                                  1, 0, 32'd700));
        send_request(make_request(REQ_RESP, 8'd1, 8'd0, 32'd0, 1'b0, 2'd2, 1, 0, 32'd710));
        send_request(make_request(REQ_RESP, 8'd2, 8'd0, 32'd0, 1'b0, 2'd3, 1, 1, 32'd720));
        // Plain responses to an idle channel and to an out-of-range one.
        send_request(make_request(REQ_RESP, 8'd4, 8'd0, 32'd0, 1'b0, KIND_PLAIN,
                                  1, 0, 32'd800));
        send_request(make_request(REQ_RESP, 8'd20, 8'd0, 32'd0, 1'b0, KIND_PLAIN,
                                  1, 0, 32'd800));
        send_request(make_request(2'd3, 8'd1, 8'd1, 32'd1, 1'b1, 0, 1, 1, 32'd900));
        send_request(make_request(REQ_SCAN, 8'd0, 8'd0, 32'd0, 1'b0, 0, 0, 0, 32'd300));
        send_request(make_request(REQ_SCAN, 8'd0, 8'd0, 32'd0, 1'b0, 0, 0, 0, 32'd40000));
        // Silent past the offline limit: the peer comes back online.
        send_request(make_request(REQ_RESP, 8'd0, 8'd0, 32'd0, 1'b0, KIND_PLAIN,
                                  1, 0, 32'd40000));
        send_request(make_request(REQ_RESP, 8'd5, 8'd0, 32'd0, 1'b0, KIND_PLAIN,
                                  1, 0, 32'd40100));
        clock_ms = 32'd50000;
        drain();

        // Everything at its low end: computed timeouts become zero.
        load_settings(16'd0, 16'd0, 16'd0, 16'd0, 32'd1);
        random_phase(100);
        drain();

        // Everything at its high end.
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        random_phase(100);
        drain();

        // Minimum above maximum, and a zero offline limit. Midway the receiver
        // holds off while requests keep coming, so the block backs up.
        load_settings(16'd500, 16'd37, 16'd20000, 16'd1000, 32'd0);
        random_phase(40);
        hold_receiver = 1'b1;
        random_phase(20);
        random_phase(40);
        drain();

        // Random settings with the clock about to wrap, and a stretch with no
        // stalls on either side.
        load_settings(16'($urandom), 16'($urandom_range(0, 300)), 16'($urandom),
                      16'($urandom), 32'($urandom_range(1, 20000)));
        clock_ms = 32'hFFFF_C000;
        random_phase(40);
        calm_stretch = 1'b1;
        random_phase(60);
        calm_stretch = 1'b0;
        random_phase(20);
        drain();

        $display("covered %0d request transactions and %0d event transactions",
                 requests_sent, events_seen);
        $display("under %0d register settings, with stalls, a long hold-off and drains",
                 settings_used);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
